[src/i2cmbe_pkg.sv]
`default_nettype none

package i2cmbe_pkg;

    localparam int TICK_W    = 16;
    localparam int BYTE_W    = 8;
    localparam int MODE_W    = 3;
    localparam int BITCNT_W  = 4;
    localparam int S_DATA_W  = 16;
    localparam int M_DATA_W  = 16;

    localparam logic [TICK_W-1:0]   PHASE_TICKS_RESET = 16'd250;
    localparam logic [BITCNT_W-1:0] BITS_PER_BYTE     = 4'd8;

    localparam logic [MODE_W-1:0] MODE_START   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_STOP    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RESTART = 3'd3;
    localparam logic [MODE_W-1:0] MODE_WRITE   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_READ    = 3'd5;

    typedef enum logic [16:0] {
        PH_IDLE  = 17'b0_0000_0000_0000_0001,
        PH_ST_A  = 17'b0_0000_0000_0000_0010,
        PH_ST_B  = 17'b0_0000_0000_0000_0100,
        PH_SP_A  = 17'b0_0000_0000_0000_1000,
        PH_SP_B  = 17'b0_0000_0000_0001_0000,
        PH_RS_A  = 17'b0_0000_0000_0010_0000,
        PH_RS_B  = 17'b0_0000_0000_0100_0000,
        PH_RS_C  = 17'b0_0000_0000_1000_0000,
        PH_RS_D  = 17'b0_0000_0001_0000_0000,
        PH_WR_LO = 17'b0_0000_0010_0000_0000,
        PH_WR_HI = 17'b0_0000_0100_0000_0000,
        PH_WR_AL = 17'b0_0000_1000_0000_0000,
        PH_WR_AH = 17'b0_0001_0000_0000_0000,
        PH_RD_LO = 17'b0_0010_0000_0000_0000,
        PH_RD_HI = 17'b0_0100_0000_0000_0000,
        PH_RD_AL = 17'b0_1000_0000_0000_0000,
        PH_RD_AH = 17'b1_0000_0000_0000_0000
    } t_phase;

endpackage

`default_nettype wire

[src/i2c_master_byte_engine_top.sv]
// the result of an accepted tick request is registered into the output register, or into the skid entry while one waits
// throughput: one tick per cycle while the skid entry is empty; the phase sequencer steps once per accepted tick
// a two-entry output register (main plus skid) keeps the input side moving while a result waits
// reset: synchronous, active low; lines released, idle, phase_ticks 250, ack latch 1
// the configuration channel is always ready
`default_nettype none

module i2c_master_byte_engine_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // tx_byte[7:0], ack_drive[8], scl_level[9], sda_level[10], zero[15:11]
    input  wire logic [i2cmbe_pkg::S_DATA_W-1:0]   s_axis_tdata,
    // mode[2:0]
    input  wire logic [i2cmbe_pkg::MODE_W-1:0]     s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // scl_drive_low[0], sda_drive_low[1], busy_res[2], done_res[3],
    // rx_byte[11:4], ack_bit[12], zero[15:13]
    output logic [i2cmbe_pkg::M_DATA_W-1:0]        m_axis_tdata,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [i2cmbe_pkg::TICK_W-1:0]     i_cfg_data
);
    import i2cmbe_pkg::*;

    // engine state
    t_phase              r_phase, n_phase;
    logic [TICK_W-1:0]   r_tick, n_tick;
    logic [BYTE_W-1:0]   r_shift, n_shift;
    logic [BITCNT_W-1:0] r_bit, n_bit;
    logic                r_ack_latch, n_ack_latch;
    logic                r_ack_send, n_ack_send;
    logic                r_scl, n_scl;
    logic                r_sda, n_sda;
    logic [BYTE_W-1:0]   r_rx, n_rx;
    logic [TICK_W-1:0]   r_phase_ticks;

    // output stage
    logic                r_out_valid, r_skid_valid;
    logic [M_DATA_W-1:0] r_out_data, r_skid_data;

    logic                accept, take;
    logic                done, do_enter, do_finish, fin_scl, fin_sda, nb;
    logic [TICK_W:0]     tc;
    logic [MODE_W-1:0]   mode;
    logic [BYTE_W-1:0]   tx_byte;
    logic                ack_drive, scl_level, sda_level;
    logic [M_DATA_W-1:0] result;

    assign mode      = s_axis_tuser;
    assign tx_byte   = s_axis_tdata[7:0];
    assign ack_drive = s_axis_tdata[8];
    assign scl_level = s_axis_tdata[9];
    assign sda_level = s_axis_tdata[10];

    assign s_axis_tready = !r_skid_valid;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign take          = r_out_valid && m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign o_cfg_ready   = 1'b1;

    assign tc = {1'b0, r_tick} + {{TICK_W{1'b0}}, 1'b1};

    always_comb begin
        n_phase     = r_phase;
        n_tick      = r_tick;
        n_shift     = r_shift;
        n_bit       = r_bit;
        n_ack_latch = r_ack_latch;
        n_ack_send  = r_ack_send;
        n_scl       = r_scl;
        n_sda       = r_sda;
        n_rx        = r_rx;
        do_enter    = 1'b0;
        do_finish   = 1'b0;
        fin_scl     = 1'b0;
        fin_sda     = 1'b0;

        if (r_phase == PH_IDLE) begin
            if (mode == MODE_START || mode == MODE_STOP || mode == MODE_RESTART ||
                mode == MODE_WRITE || mode == MODE_READ) begin
                n_bit    = '0;
                do_enter = 1'b1;
                case (mode)
                    MODE_START:   n_phase = PH_ST_A;
                    MODE_STOP:    n_phase = PH_SP_A;
                    MODE_RESTART: n_phase = PH_RS_A;
                    MODE_WRITE: begin
                        n_shift = tx_byte;
                        n_phase = PH_WR_LO;
                    end
                    default: begin
                        n_shift    = '0;
                        n_ack_send = ack_drive;
                        n_phase    = PH_RD_LO;
                    end
                endcase
            end
        end else if (r_phase == PH_RD_HI && !scl_level) begin
            // clock stretching: only consecutive high ticks count
            n_tick = '0;
        end else if (tc >= {1'b0, r_phase_ticks}) begin
            case (r_phase)
                PH_ST_A: begin n_phase = PH_ST_B;  do_enter = 1'b1; end
                PH_ST_B: begin do_finish = 1'b1; fin_scl = 1'b1; fin_sda = 1'b1; end
                PH_SP_A: begin n_phase = PH_SP_B;  do_enter = 1'b1; end
                PH_SP_B: begin do_finish = 1'b1; end
                PH_RS_A: begin n_phase = PH_RS_B;  do_enter = 1'b1; end
                PH_RS_B: begin n_phase = PH_RS_C;  do_enter = 1'b1; end
                PH_RS_C: begin n_phase = PH_RS_D;  do_enter = 1'b1; end
                PH_RS_D: begin do_finish = 1'b1; fin_scl = 1'b1; fin_sda = 1'b1; end
                PH_WR_LO: begin n_phase = PH_WR_HI; do_enter = 1'b1; end
                PH_WR_HI: begin
                    n_shift  = {r_shift[BYTE_W-2:0], 1'b0};
                    n_bit    = r_bit + BITCNT_W'(1);
                    n_phase  = (n_bit >= BITS_PER_BYTE) ? PH_WR_AL : PH_WR_LO;
                    do_enter = 1'b1;
                end
                PH_WR_AL: begin n_phase = PH_WR_AH; do_enter = 1'b1; end
                PH_WR_AH: begin
                    n_ack_latch = sda_level;
                    do_finish   = 1'b1;
                    fin_scl     = 1'b1;
                end
                PH_RD_LO: begin n_phase = PH_RD_HI; do_enter = 1'b1; end
                PH_RD_HI: begin
                    n_shift  = {r_shift[BYTE_W-2:0], sda_level};
                    n_bit    = r_bit + BITCNT_W'(1);
                    n_phase  = (n_bit >= BITS_PER_BYTE) ? PH_RD_AL : PH_RD_LO;
                    do_enter = 1'b1;
                end
                PH_RD_AL: begin n_phase = PH_RD_AH; do_enter = 1'b1; end
                PH_RD_AH: begin
                    n_rx      = r_shift;
                    do_finish = 1'b1;
                    fin_scl   = 1'b1;
                end
                default: begin
                    do_finish = 1'b1;
                    fin_scl   = r_scl;
                    fin_sda   = r_sda;
                end
            endcase
        end else begin
            n_tick = tc[TICK_W-1:0];
        end

        // data bit drive is the inverse of the current msb
        nb = ~n_shift[BYTE_W-1];

        if (do_enter) begin
            n_tick = '0;
            case (n_phase)
                PH_ST_A:  begin n_scl = 1'b0; n_sda = 1'b1; end
                PH_ST_B:  begin n_scl = 1'b1; n_sda = 1'b1; end
                PH_SP_A:  begin n_scl = 1'b1; n_sda = 1'b1; end
                PH_SP_B:  begin n_scl = 1'b0; n_sda = 1'b1; end
                PH_RS_A:  begin n_scl = 1'b1; n_sda = 1'b0; end
                PH_RS_B:  begin n_scl = 1'b0; n_sda = 1'b0; end
                PH_RS_C:  begin n_scl = 1'b0; n_sda = 1'b1; end
                PH_RS_D:  begin n_scl = 1'b1; n_sda = 1'b1; end
                PH_WR_LO: begin n_scl = 1'b1; n_sda = nb;   end
                PH_WR_HI: begin n_scl = 1'b0; n_sda = nb;   end
                PH_WR_AL: begin n_scl = 1'b1; n_sda = 1'b0; end
                PH_WR_AH: begin n_scl = 1'b0; n_sda = 1'b0; end
                PH_RD_LO: begin n_scl = 1'b1; n_sda = 1'b0; end
                PH_RD_HI: begin n_scl = 1'b0; n_sda = 1'b0; end
                PH_RD_AL: begin n_scl = 1'b1; n_sda = n_ack_send; end
                PH_RD_AH: begin n_scl = 1'b0; n_sda = n_ack_send; end
                default:  begin n_scl = r_scl; n_sda = r_sda; end
            endcase
        end

        done = do_finish;
        if (do_finish) begin
            n_phase = PH_IDLE;
            n_tick  = '0;
            n_scl   = fin_scl;
            n_sda   = fin_sda;
        end
    end

    assign result = {3'b000, n_ack_latch, n_rx, done, (n_phase != PH_IDLE), n_sda, n_scl};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_tick        <= '0;
            r_shift       <= '0;
            r_bit         <= '0;
            r_ack_latch   <= 1'b1;
            r_ack_send    <= 1'b0;
            r_scl         <= 1'b0;
            r_sda         <= 1'b0;
            r_rx          <= '0;
            r_phase_ticks <= PHASE_TICKS_RESET;
        end else begin
            if (i_cfg_valid) begin
                r_phase_ticks <= i_cfg_data;
            end
            if (accept) begin
                r_phase     <= n_phase;
                r_tick      <= n_tick;
                r_shift     <= n_shift;
                r_bit       <= n_bit;
                r_ack_latch <= n_ack_latch;
                r_ack_send  <= n_ack_send;
                r_scl       <= n_scl;
                r_sda       <= n_sda;
                r_rx        <= n_rx;
            end
        end
    end

    // output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (take) begin
                if (r_skid_valid) begin
                    r_skid_valid <= 1'b0;
                end else if (!accept) begin
                    r_out_valid <= 1'b0;
                end
            end else if (accept && r_out_valid) begin
                r_skid_valid <= 1'b1;
            end else if (accept) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            if (r_skid_valid) begin
                r_out_data <= r_skid_data;
            end else if (accept) begin
                r_out_data <= result;
            end
        end else if (accept && r_out_valid) begin
            r_skid_data <= result;
        end else if (accept) begin
            r_out_data <= result;
        end
    end

endmodule

`default_nettype wire

[tb/testbench.sv]
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cmbe_pkg::*;

    localparam time CLK_HALF    = 4ns;
    localparam int  CYCLE_LIMIT = 1_000_000;
    localparam int  RAND_PER_SET = 105;

    localparam logic [MODE_W-1:0] MODE_NONE = 3'd0;
    localparam logic [MODE_W-1:0] MODE_BAD6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_BAD7 = 3'd7;

    // phase_ticks used by the four random sets, lowest set in the lowest bits
    localparam logic [63:0] RAND_TICKS = {16'd3, 16'd1, 16'd2, 16'd1};

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [7:0]        tx;
        logic              sack;
        logic              scl;
        logic              sda;
    } t_bus_tick;

    // laid out as on m_axis_tdata[12:0]
    typedef struct packed {
        logic       ack;
        logic [7:0] rx;
        logic       done;
        logic       busy;
        logic       sda_low;
        logic       scl_low;
    } t_bus_res;

    typedef struct {
        logic        is_cfg;
        logic [15:0] cfg_val;
        t_bus_tick   stim;
        logic        pinned;
        t_bus_res    want;
    } t_script_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_DATA_W-1:0]  s_axis_tdata;
    logic [MODE_W-1:0]    s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b1;
    logic [M_DATA_W-1:0]  m_axis_tdata;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [TICK_W-1:0]    i_cfg_data;

    // engine state as predicted from the accepted requests
    logic [TICK_W-1:0]    ptk = PHASE_TICKS_RESET;
    t_phase               ph = PH_IDLE;
    logic [3:0]           bits = '0;
    logic [7:0]           shreg = '0;
    logic [TICK_W-1:0]    tcnt = '0;
    logic                 ack_latch = 1'b1;
    logic                 ack_out = 1'b0;
    logic                 scl_pull = 1'b0;
    logic                 sda_pull = 1'b0;
    logic [7:0]           rx_hold = '0;

    t_bus_res             awaited[$];
    t_bus_tick            plan[$];
    t_script_row          script[$];
    logic                 drv_pinned;
    t_bus_res             drv_want;
    int                   ticks_taken = 0;
    int                   cfg_taken = 0;
    int                   fail_count = 0;
    int                   cycles = 0;
    int                   send_idle_pct = 0;
    int                   stall_pct = 0;

    i2c_master_byte_engine_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    function automatic void pull_lines(input logic scl, input logic sda);
        scl_pull = scl;
        sda_pull = sda;
    endfunction

    function automatic void enter_phase(input t_phase p);
        logic nb;
        nb = ~shreg[7];
        ph = p;
        tcnt = '0;
        case (p)
            PH_ST_A, PH_SP_B, PH_RS_C:   pull_lines(1'b0, 1'b1);
            PH_ST_B, PH_SP_A, PH_RS_D:   pull_lines(1'b1, 1'b1);
            PH_RS_A, PH_WR_AL, PH_RD_LO: pull_lines(1'b1, 1'b0);
            PH_RS_B, PH_WR_AH, PH_RD_HI: pull_lines(1'b0, 1'b0);
            PH_WR_LO:                    pull_lines(1'b1, nb);
            PH_WR_HI:                    pull_lines(1'b0, nb);
            PH_RD_AL:                    pull_lines(1'b1, ack_out);
            PH_RD_AH:                    pull_lines(1'b0, ack_out);
            default: ;
        endcase
    endfunction

    // leaves the current phase, returns 1 when the command has finished
    function automatic logic leave_phase(input logic sda_in);
        logic fin;
        logic rd;
        fin = 1'b0;
        rd = (ph == PH_RD_HI);
        case (ph)
            PH_ST_A:  enter_phase(PH_ST_B);
            PH_SP_A:  enter_phase(PH_SP_B);
            PH_RS_A:  enter_phase(PH_RS_B);
            PH_RS_B:  enter_phase(PH_RS_C);
            PH_RS_C:  enter_phase(PH_RS_D);
            PH_WR_LO: enter_phase(PH_WR_HI);
            PH_WR_AL: enter_phase(PH_WR_AH);
            PH_RD_LO: enter_phase(PH_RD_HI);
            PH_RD_AL: enter_phase(PH_RD_AH);
            PH_WR_HI, PH_RD_HI: begin
                shreg = {shreg[6:0], rd & sda_in};
                bits = bits + 4'd1;
                if (bits >= BITS_PER_BYTE) enter_phase(rd ? PH_RD_AL : PH_WR_AL);
                else enter_phase(rd ? PH_RD_LO : PH_WR_LO);
            end
            PH_ST_B, PH_RS_D: begin
                pull_lines(1'b1, 1'b1);
                fin = 1'b1;
            end
            PH_SP_B: begin
                pull_lines(1'b0, 1'b0);
                fin = 1'b1;
            end
            PH_WR_AH: begin
                ack_latch = sda_in;
                pull_lines(1'b1, 1'b0);
                fin = 1'b1;
            end
            PH_RD_AH: begin
                rx_hold = shreg;
                pull_lines(1'b1, 1'b0);
                fin = 1'b1;
            end
            default: fin = 1'b1;
        endcase
        if (fin) begin
            ph = PH_IDLE;
            tcnt = '0;
        end
        return fin;
    endfunction

    function automatic logic is_command(input logic [MODE_W-1:0] m);
        return m == MODE_START || m == MODE_STOP || m == MODE_RESTART ||
               m == MODE_WRITE || m == MODE_READ;
    endfunction

    function automatic t_bus_res i2c_tick(input t_bus_tick t);
        t_bus_res    r;
        logic        fin;
        logic [16:0] tc;
        fin = 1'b0;
        if (ph == PH_IDLE) begin
            if (is_command(t.mode)) bits = '0;
            case (t.mode)
                MODE_START:   enter_phase(PH_ST_A);
                MODE_STOP:    enter_phase(PH_SP_A);
                MODE_RESTART: enter_phase(PH_RS_A);
                MODE_WRITE: begin
                    shreg = t.tx;
                    enter_phase(PH_WR_LO);
                end
                MODE_READ: begin
                    shreg = '0;
                    ack_out = t.sack;
                    enter_phase(PH_RD_LO);
                end
                default: ;
            endcase
        end else if (ph == PH_RD_HI && !t.scl) begin
            // slave stretching the clock: only consecutive high ticks count
            tcnt = '0;
        end else begin
            tc = {1'b0, tcnt} + 17'd1;
            if (tc >= {1'b0, ptk}) fin = leave_phase(t.sda);
            else tcnt = tc[15:0];
        end
        r.scl_low = scl_pull;
        r.sda_low = sda_pull;
        r.busy    = (ph != PH_IDLE);
        r.done    = fin;
        r.rx      = rx_hold;
        r.ack     = ack_latch;
        return r;
    endfunction

    function automatic t_bus_tick mk_tick(input logic [MODE_W-1:0] m, input logic [7:0] tx,
                                          input logic sack, input logic scl, input logic sda);
        t_bus_tick t;
        t.mode = m;
        t.tx   = tx;
        t.sack = sack;
        t.scl  = scl;
        t.sda  = sda;
        return t;
    endfunction

    function automatic t_bus_tick quiet_tick();
        return mk_tick(MODE_NONE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                       1'b1, 1'($urandom_range(0, 1)));
    endfunction

    function automatic t_script_row tick_row(input t_bus_tick t);
        t_script_row r;
        r.is_cfg  = 1'b0;
        r.cfg_val = '0;
        r.stim    = t;
        r.pinned  = 1'b0;
        r.want    = '0;
        return r;
    endfunction

    function automatic t_script_row cfg_row(input logic [15:0] v);
        t_script_row r;
        r = tick_row('0);
        r.is_cfg  = 1'b1;
        r.cfg_val = v;
        return r;
    endfunction

    // start, address, optional repeated start and second address, one to three data bytes, stop
    function automatic void plan_transaction();
        int   nbytes;
        logic rd;
        rd = 1'($urandom_range(0, 1));
        nbytes = $urandom_range(1, 3);
        plan.push_back(mk_tick(MODE_START, '0, 1'b0, 1'b1, 1'b1));
        plan.push_back(mk_tick(MODE_WRITE, 8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b1));
        if (rd && $urandom_range(0, 1) == 1) begin
            plan.push_back(mk_tick(MODE_RESTART, '0, 1'b0, 1'b1, 1'b1));
            plan.push_back(mk_tick(MODE_WRITE, 8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b1));
        end
        for (int i = 0; i < nbytes; i++) begin
            plan.push_back(mk_tick(rd ? MODE_READ : MODE_WRITE, 8'($urandom_range(0, 255)),
                                   (i == nbytes - 1) ? ($urandom_range(0, 9) == 0)
                                                     : ($urandom_range(0, 9) != 0),
                                   1'b1, 1'b1));
        end
        plan.push_back(mk_tick(MODE_STOP, '0, 1'b0, 1'b1, 1'b1));
    endfunction

    function automatic t_bus_tick next_tick();
        t_bus_tick t;
        t_bus_tick p;
        int        r;
        t = quiet_tick();
        t.sack = 1'($urandom_range(0, 1));
        t.scl = (ph == PH_RD_HI) ? ($urandom_range(0, 99) >= 35) : 1'($urandom_range(0, 1));
        if (ph == PH_IDLE) begin
            r = $urandom_range(0, 99);
            if (r < 3) plan.delete();
            if (r < 12) begin
                t.mode = 3'($urandom_range(0, 7));
            end else if (r >= 20) begin
                if (plan.size() == 0) plan_transaction();
                p = plan.pop_front();
                t.mode = p.mode;
                t.tx   = p.tx;
                t.sack = p.sack;
            end
        end else if ($urandom_range(0, 99) < 15) begin
            t.mode = 3'($urandom_range(0, 7));
        end
        return t;
    endfunction

    task automatic note_fail(input string what, input t_bus_res want, input t_bus_res got,
                             input logic [2:0] pad);
        fail_count++;
        if (fail_count <= 10) begin
            $write("%0t %s: scl %b/%b sda %b/%b busy %b/%b", $realtime, what,
                   want.scl_low, got.scl_low, want.sda_low, got.sda_low,
                   want.busy, got.busy);
            $display(" done %b/%b rx %02h/%02h ack %b/%b pad %b (exp/act)",
                     want.done, got.done, want.rx, got.rx, want.ack, got.ack, pad);
        end
    endtask

    always @(posedge i_clk) begin
        t_bus_res  got;
        t_bus_res  want;
        t_bus_tick t;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_bus_res'(m_axis_tdata[12:0]);
                if (awaited.size() == 0) begin
                    note_fail("unexpected result", '0, got, m_axis_tdata[15:13]);
                end else begin
                    want = awaited.pop_front();
                    if (got !== want || m_axis_tdata[15:13] !== 3'b000)
                        note_fail("result mismatch", want, got, m_axis_tdata[15:13]);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                t = mk_tick(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[8],
                            s_axis_tdata[9], s_axis_tdata[10]);
                want = i2c_tick(t);
                awaited.push_back(drv_pinned ? drv_want : want);
                ticks_taken++;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                ptk = i_cfg_data;
                cfg_taken++;
            end
        end
    end

    always @(negedge i_clk) m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);

    task automatic drive_tick(input t_bus_tick t, input logic pinned, input t_bus_res want);
        int target;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, t.sda, t.scl, t.sack, t.tx};
        s_axis_tuser  <= t.mode;
        drv_pinned    <= pinned;
        drv_want      <= want;
        target = ticks_taken + 1;
        do @(negedge i_clk); while (ticks_taken != target);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (awaited.size() != 0) @(negedge i_clk);
    endtask

    // runs the engine back to idle and drains results before the register moves
    task automatic set_phase_ticks(input logic [15:0] v);
        int target;
        while (ph != PH_IDLE) drive_tick(quiet_tick(), 1'b0, '0);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        target = cfg_taken + 1;
        do @(negedge i_clk); while (cfg_taken != target);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        t_script_row row;
        t_bus_tick   t;
        int          counted;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= MODE_NONE;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= '0;
        drv_pinned    <= 1'b0;
        drv_want      <= '0;

        // idle tick straight out of reset
        row = tick_row(mk_tick(MODE_NONE, 8'h00, 1'b0, 1'b1, 1'b1));
        row.pinned = 1'b1;
        row.want = '{ack: 1'b1, rx: 8'h00, done: 1'b0, busy: 1'b0,
                     sda_low: 1'b0, scl_low: 1'b0};
        script.push_back(row);
        script.push_back(cfg_row(16'd1));
        // start drives the first phase on its own tick
        row = tick_row(mk_tick(MODE_START, 8'h00, 1'b0, 1'b0, 1'b0));
        row.pinned = 1'b1;
        row.want = '{ack: 1'b1, rx: 8'h00, done: 1'b0, busy: 1'b1,
                     sda_low: 1'b1, scl_low: 1'b0};
        script.push_back(row);
        // a command while busy is dropped
        script.push_back(tick_row(mk_tick(MODE_WRITE, 8'hFF, 1'b1, 1'b1, 1'b1)));
        script.push_back(tick_row(mk_tick(MODE_NONE, 8'h00, 1'b0, 1'b0, 1'b0)));
        // unknown modes at idle do nothing
        script.push_back(tick_row(mk_tick(MODE_BAD7, 8'h00, 1'b0, 1'b0, 1'b1)));
        script.push_back(tick_row(mk_tick(MODE_BAD6, 8'hFF, 1'b1, 1'b1, 1'b0)));
        script.push_back(tick_row(mk_tick(MODE_RESTART, 8'h5A, 1'b0, 1'b1, 1'b1)));
        script.push_back(tick_row(mk_tick(MODE_NONE, 8'h00, 1'b0, 1'b1, 1'b1)));
        script.push_back(tick_row(mk_tick(MODE_NONE, 8'h00, 1'b0, 1'b1, 1'b1)));
        script.push_back(tick_row(mk_tick(MODE_NONE, 8'h00, 1'b0, 1'b1, 1'b1)));
        // stop on the done tick is ignored, the next one runs
        script.push_back(tick_row(mk_tick(MODE_STOP, 8'h00, 1'b0, 1'b1, 1'b1)));
        script.push_back(tick_row(mk_tick(MODE_STOP, 8'h00, 1'b0, 1'b1, 1'b1)));
        script.push_back(tick_row(mk_tick(MODE_NONE, 8'h00, 1'b0, 1'b1, 1'b1)));
        script.push_back(tick_row(mk_tick(MODE_NONE, 8'h00, 1'b0, 1'b1, 1'b1)));
        // zero behaves as one tick per phase
        script.push_back(cfg_row(16'd0));
        script.push_back(tick_row(mk_tick(MODE_READ, 8'h00, 1'b0, 1'b0, 1'b0)));
        script.push_back(tick_row(mk_tick(MODE_NONE, 8'h00, 1'b0, 1'b0, 1'b0)));
        // clock stretching in the read high phase
        script.push_back(tick_row(mk_tick(MODE_NONE, 8'h00, 1'b0, 1'b0, 1'b1)));
        script.push_back(tick_row(mk_tick(MODE_NONE, 8'h00, 1'b0, 1'b0, 1'b1)));
        script.push_back(tick_row(mk_tick(MODE_NONE, 8'h00, 1'b0, 1'b1, 1'b1)));
        script.push_back(tick_row(mk_tick(MODE_WRITE, 8'hFF, 1'b1, 1'b1, 1'b1)));

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (script[i]) begin
            if (script[i].is_cfg) set_phase_ticks(script[i].cfg_val);
            else drive_tick(script[i].stim, script[i].pinned, script[i].want);
        end

        for (int p = 0; p < 4; p++) begin
            set_phase_ticks(RAND_TICKS[p*16 +: 16]);
            send_idle_pct = (p == 1) ? 46 : (p == 3) ? 12 : 0;
            stall_pct     = (p == 2) ? 46 : (p == 3) ? 12 : 0;
            counted = 0;
            while (counted < RAND_PER_SET) begin
                t = next_tick();
                if (ph != PH_IDLE || is_command(t.mode)) counted++;
                drive_tick(t, 1'b0, '0);
                if ($urandom_range(0, 99) < 2) settle();
            end
        end

        settle();
        repeat (20) @(negedge i_clk);
        if (fail_count == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
